// ===== sv/sbd_pkg.sv =====
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared constants and types for the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sbd_pkg;

	localparam logic [7:0]  StartByte  = 8'h0F;
	localparam logic [7:0]  EndByte    = 8'h00;
	localparam logic [4:0]  HuntPos    = 5'd0;
	localparam logic [4:0]  DataLast   = 5'd22;
	localparam logic [4:0]  FlagPos    = 5'd23;
	localparam logic [4:0]  WaitPos    = 5'd24;
	localparam logic [4:0]  ChanBits   = 5'd11;
	localparam logic [25:0] PctScale   = 26'd25600;
	localparam logic [25:0] PctRound   = 26'd1023;
	localparam logic [10:0] RawMax     = 11'd2047;

	localparam int FsBit  = 4;
	localparam int D17Bit = 7;
	localparam int D18Bit = 6;

	typedef struct packed {
		logic        channel_valid;
		logic [3:0]  channel_index;
		logic [10:0] channel_raw;
		logic [14:0] channel_percent;
		logic        flags_valid;
		logic        digital_ch17;
		logic        digital_ch18;
		logic        failsafe_flag;
		logic        frame_end;
	} result_t;

endpackage

// ===== sv/sbus_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// SBUS receive frame decoder: start byte hunt, 16 x 11-bit channel unpack
// with Q7.8 percent scaling, flag byte and end byte handling.
// ----------------------------------------------------------------------------
//  channel | handshake                    | payload
//  byte    | byte_valid / byte_stall      | data_byte
//  result  | result_valid / result_stall  | channel_*, flags_valid, digital_ch17,
//          |                              | digital_ch18, failsafe_flag, frame_end
//
//  One byte per cycle while not stalled; bytes pass the input register,
//  then the result register. Every byte yields exactly one result word.
//  Reset clears frame position, counters, partial bits and failsafe latch.
//  result_stall holds the result register; byte_stall rises only when both
//  registers are full.
// ----------------------------------------------------------------------------
module sbus_frame_decoder
	import sbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        channel_valid,
	output logic [3:0]  channel_index,
	output logic [10:0] channel_raw,
	output logic [14:0] channel_percent,
	output logic        flags_valid,
	output logic        digital_ch17,
	output logic        digital_ch18,
	output logic        failsafe_flag,
	output logic        frame_end
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res;
	logic       advance;
	logic       load;

	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign byte_stall = valid_s1 && !advance;
	assign load       = byte_valid && !byte_stall;

	sbd_unpack u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (!result_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			byte_s1 <= data_byte;
		if (advance)
			res_s2 <= res;
	end

	assign result_valid    = valid_s2;
	assign channel_valid   = res_s2.channel_valid;
	assign channel_index   = res_s2.channel_index;
	assign channel_raw     = res_s2.channel_raw;
	assign channel_percent = res_s2.channel_percent;
	assign flags_valid     = res_s2.flags_valid;
	assign digital_ch17    = res_s2.digital_ch17;
	assign digital_ch18    = res_s2.digital_ch18;
	assign failsafe_flag   = res_s2.failsafe_flag;
	assign frame_end       = res_s2.frame_end;

endmodule

// ===== sv/sbd_scale.sv =====
// ----------------------------------------------------------------------------
// sbd_scale
// Raw 11-bit channel to Q7.8 percent: round(raw * 25600 / 2047).
// ----------------------------------------------------------------------------
module sbd_scale
	import sbd_pkg::*;
(
	input  logic [10:0] raw,
	output logic [14:0] percent
);

	logic [25:0] num;
	logic [14:0] hi1;
	logic [10:0] lo1;
	logic [15:0] sum1;
	logic [4:0]  hi2;
	logic [11:0] sum2;
	logic [15:0] quot;

	// x / 2047 with x = 2048*h + l = 2047*h + (h + l), folded twice,
	// then one compare for the last step.
	always_comb begin
		num  = {15'd0, raw} * PctScale + PctRound;
		hi1  = num[25:11];
		lo1  = num[10:0];
		sum1 = {1'b0, hi1} + {5'd0, lo1};
		hi2  = sum1[15:11];
		sum2 = {7'd0, hi2} + {1'b0, sum1[10:0]};
		quot = {1'b0, hi1} + {11'd0, hi2}
			+ {15'd0, (sum2 >= {1'b0, RawMax})};
		percent = quot[14:0];
	end

endmodule

// ===== sv/sbd_unpack.sv =====
// ----------------------------------------------------------------------------
// sbd_unpack
// Frame tracking and LSB-first bit unpacking, one byte per step.
// ----------------------------------------------------------------------------
module sbd_unpack
	import sbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	output result_t     res
);

	logic [4:0]  pos_q;
	logic [4:0]  chan_q;
	logic [3:0]  bits_q;
	logic [10:0] part_q;
	logic        fs_q;

	logic [4:0]  pos_d;
	logic [4:0]  chan_d;
	logic [3:0]  bits_d;
	logic [10:0] part_d;
	logic        fs_d;

	logic [4:0]  total;
	logic [17:0] shifted;
	logic [10:0] merged;
	logic [2:0]  rest;
	logic [3:0]  rshift;
	logic [14:0] pct;

	sbd_scale u_scale (
		.raw     (merged),
		.percent (pct)
	);

	always_comb begin
		total   = {1'b0, bits_q} + 5'd8;
		shifted = {10'd0, data_byte} << bits_q;
		merged  = part_q | shifted[10:0];
		rest    = 3'(total - ChanBits);
		rshift  = 4'd8 - {1'b0, rest};

		pos_d  = pos_q;
		chan_d = chan_q;
		bits_d = bits_q;
		part_d = part_q;
		fs_d   = fs_q;
		res    = '0;

		if (pos_q == HuntPos) begin
			if (data_byte == StartByte)
				pos_d = 5'd1;
		end else if (pos_q <= DataLast) begin
			if (total >= ChanBits) begin
				res.channel_valid   = 1'b1;
				res.channel_index   = chan_q[3:0];
				res.channel_raw     = merged;
				res.channel_percent = pct;
				chan_d = chan_q + 5'd1;
				part_d = {3'd0, data_byte >> rshift};
				bits_d = {1'b0, rest};
			end else begin
				part_d = merged;
				bits_d = total[3:0];
			end
			pos_d = pos_q + 5'd1;
		end else if (pos_q == FlagPos) begin
			fs_d = data_byte[FsBit];
			res.flags_valid  = 1'b1;
			res.digital_ch17 = data_byte[D17Bit];
			res.digital_ch18 = data_byte[D18Bit];
			chan_d = chan_q + 5'd2;
			pos_d  = WaitPos;
		end else if (data_byte == EndByte) begin
			pos_d  = HuntPos;
			chan_d = '0;
			bits_d = '0;
			part_d = '0;
			res.frame_end = 1'b1;
		end

		res.failsafe_flag = fs_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			chan_q <= '0;
			bits_q <= '0;
			part_q <= '0;
			fs_q   <= 1'b0;
		end else if (step) begin
			pos_q  <= pos_d;
			chan_q <= chan_d;
			bits_q <= bits_d;
			part_q <= part_d;
			fs_q   <= fs_d;
		end
	end

endmodule

// ===== sv/sbd_checker.sv =====
// ----------------------------------------------------------------------------
// sbd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module sbd_checker
	import sbd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic        channel_valid,
	input logic [3:0]  channel_index,
	input logic [10:0] channel_raw,
	input logic [14:0] channel_percent,
	input logic        flags_valid,
	input logic        digital_ch17,
	input logic        digital_ch18,
	input logic        frame_end
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(channel_raw)
			&& $stable(channel_percent) && $stable(channel_valid))
		else $error("stalled result changed");

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0({channel_valid, flags_valid, frame_end}))
		else $error("more than one event in a result word");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && channel_valid |-> channel_percent <= 15'd25600
			&& (channel_raw != RawMax || channel_percent == 15'd25600))
		else $error("percent out of range");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !channel_valid |-> channel_index == 4'd0
			&& channel_raw == 11'd0 && channel_percent == 15'd0)
		else $error("channel fields set without a channel");

	a_flags_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !flags_valid |-> !digital_ch17 && !digital_ch18)
		else $error("digital channels set without a flag byte");

endmodule

bind sbus_frame_decoder sbd_checker u_sbd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.result_valid    (result_valid),
	.result_stall    (result_stall),
	.channel_valid   (channel_valid),
	.channel_index   (channel_index),
	.channel_raw     (channel_raw),
	.channel_percent (channel_percent),
	.flags_valid     (flags_valid),
	.digital_ch17    (digital_ch17),
	.digital_ch18    (digital_ch18),
	.frame_end       (frame_end)
);
